// ----- src/budgeted_greedy_cover_select_defines.svh -----
// assertion macros for the greedy cover selector
// no dependencies
`ifndef BUDGETED_GREEDY_COVER_SELECT_DEFINES_SVH
`define BUDGETED_GREEDY_COVER_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define BGCS_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BGCS_ASSERT_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BGCS_ASSERT(lbl, prop, msg)
`define BGCS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- src/bgcs_pkg.sv -----
// types and constants for the greedy cover selector
// no dependencies
package bgcs_pkg;
  // store depths, fixed by the 5-bit slot field and the 16-bit region masks
  localparam int MAX_REGIONS    = 16;
  localparam int MAX_CANDIDATES = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD_REGION = 2'd0,
    FUNC_LOAD_CAND   = 2'd1,
    FUNC_RUN         = 2'd2,
    FUNC_NONE        = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CFG_REGION_COUNT = 3'd0,
    CFG_CAND_COUNT   = 3'd1,
    CFG_MAX_SELECTED = 3'd2,
    CFG_MAX_CLONE    = 3'd3,
    CFG_MAX_MICRO    = 3'd4,
    CFG_START_CLONE  = 3'd5,
    CFG_START_MICRO  = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_SCAN, ST_APPLY, ST_CHECK, ST_EMIT
  } state_e;
endpackage

// ----- src/budgeted_greedy_cover_select.sv -----
// Budgeted greedy cover selector: one scan unit walks the candidates one per cycle.
// A run repeats a scan of all candidates with the single candidate compare unit for
// each pick, then delivers its result transactions. Depends on bgcs_pkg and
// budgeted_greedy_cover_select_defines.svh.
`include "budgeted_greedy_cover_select_defines.svh"
module budgeted_greedy_cover_select import bgcs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func, slot, region_peak, region_target, candidate_regions, candidate_benefit,
  // candidate_clone_ops, candidate_micro_ops, zero pad
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // chosen_slot, has_choice, fallback, total_clone_ops, total_micro_ops, zero pad
  output logic [55:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  localparam int RW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_CANDIDATES);
  localparam int NC = MAX_CANDIDATES > 32 ? 32 : MAX_CANDIDATES;
  localparam int NR = MAX_REGIONS > 16 ? 16 : MAX_REGIONS;

  // configuration registers
  logic [4:0]  reg_cnt_q;
  logic [5:0]  cand_cnt_q, max_sel_q;
  logic [15:0] max_clone_q, start_clone_q;
  logic [31:0] max_micro_q, start_micro_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_cnt_q <= '0; cand_cnt_q <= '0; max_sel_q <= 6'd32;
      max_clone_q <= 16'hffff; max_micro_q <= 32'hffffffff;
      start_clone_q <= '0; start_micro_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_REGION_COUNT: reg_cnt_q <= cfg_data_i[4:0];
        CFG_CAND_COUNT:   cand_cnt_q <= cfg_data_i[5:0];
        CFG_MAX_SELECTED: max_sel_q <= cfg_data_i[5:0];
        CFG_MAX_CLONE:    max_clone_q <= cfg_data_i[15:0];
        CFG_MAX_MICRO:    max_micro_q <= cfg_data_i;
        CFG_START_CLONE:  start_clone_q <= cfg_data_i[15:0];
        CFG_START_MICRO:  start_micro_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic [1:0] in_func; logic [4:0] in_slot;
  logic [15:0] in_peak, in_tgt, in_mask, in_ben, in_clone; logic [31:0] in_micro;
  assign in_func = s_axis_tdata[1:0];
  assign in_slot = s_axis_tdata[6:2];
  assign in_peak = s_axis_tdata[22:7];
  assign in_tgt = s_axis_tdata[38:23];
  assign in_mask = s_axis_tdata[54:39];
  assign in_ben = s_axis_tdata[70:55];
  assign in_clone = s_axis_tdata[86:71];
  assign in_micro = s_axis_tdata[118:87];

  // stores, each entry read at the scan index or at a fixed place
  logic [16:0] deficit_q [MAX_REGIONS];
  logic [15:0] cmask_q [MAX_CANDIDATES], cben_q [MAX_CANDIDATES], cclone_q [MAX_CANDIDATES];
  logic [31:0] cmicro_q [MAX_CANDIDATES];
  logic [4:0]  order_q [32];

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  always_ff @(posedge clk_i) begin
    if (s_acc && in_func == FUNC_LOAD_REGION && 32'(in_slot) < MAX_REGIONS)
      deficit_q[in_slot[RW-1:0]] <= {1'b0, in_peak} - {1'b0, in_tgt};
    if (s_acc && in_func == FUNC_LOAD_CAND && 32'(in_slot) < MAX_CANDIDATES) begin
      cmask_q[in_slot[CW-1:0]]  <= in_mask;
      cben_q[in_slot[CW-1:0]]   <= in_ben;
      cclone_q[in_slot[CW-1:0]] <= in_clone;
      cmicro_q[in_slot[CW-1:0]] <= in_micro;
    end
  end

  // working state
  state_e state_q, state_d;
  logic [MAX_REGIONS-1:0] need_q;   // bit r: working deficit of region r still positive
  logic [16:0] work_q [MAX_REGIONS];
  logic [31:0] picked_q;
  logic [5:0]  cnt_q, idx_q;
  logic [16:0] clone_sum_q;
  logic [32:0] micro_sum_q;
  logic        found_q, fb_q;
  logic [4:0]  best_q;
  logic [4:0]  best_help_q;
  logic [15:0] best_ben_q;
  logic [31:0] best_micro_q;
  logic [5:0]  out_k_q;

  logic [4:0] nreg; logic [5:0] ncand;
  assign nreg = 32'(reg_cnt_q) > MAX_REGIONS ? 5'(MAX_REGIONS) : reg_cnt_q;
  assign ncand = 32'(cand_cnt_q) > NC ? 6'(NC) : cand_cnt_q;

  // candidate evaluation unit
  logic [4:0] ci; logic [15:0] cm; logic [15:0] useful; logic [4:0] help;
  logic fit, better;
  assign ci = idx_q[4:0];
  assign cm = cmask_q[ci[CW-1:0] ];
  always_comb begin
    useful = '0;
    for (int r = 0; r < NR; r++) useful[r] = cm[r] && need_q[r] && (r < nreg);
    help = 5'($countones(useful));
    fit = (cnt_q < max_sel_q) && (clone_sum_q <= {1'b0, max_clone_q}) &&
          ({1'b0, cclone_q[ci[CW-1:0]]} <= {1'b0, max_clone_q} - clone_sum_q) &&
          (micro_sum_q <= {1'b0, max_micro_q}) &&
          ({1'b0, cmicro_q[ci[CW-1:0]]} <= {1'b0, max_micro_q} - micro_sum_q);
    if (!found_q) better = 1'b1;
    else if (help != best_help_q) better = help > best_help_q;
    else if (cben_q[ci[CW-1:0]] != best_ben_q) better = cben_q[ci[CW-1:0]] > best_ben_q;
    else better = cmicro_q[ci[CW-1:0]] < best_micro_q;
  end

  // sequencer next state
  logic out_valid; logic out_take;
  assign out_take = m_axis_tvalid && m_axis_tready;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_acc && in_func == FUNC_RUN) state_d = ST_INIT;
      ST_INIT:  state_d = ST_CHECK;
      ST_CHECK: state_d = (|need_q) ? ST_SCAN : ST_EMIT;
      ST_SCAN:  if (idx_q + 6'd1 >= ncand || ncand == 6'd0) state_d = ST_APPLY;
      ST_APPLY: state_d = found_q ? ST_CHECK : ST_EMIT;
      ST_EMIT:  if (out_take && m_axis_tlast) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; need_q <= '0; picked_q <= '0; cnt_q <= '0; idx_q <= '0;
      clone_sum_q <= '0; micro_sum_q <= '0; found_q <= 1'b0; fb_q <= 1'b0; out_k_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_INIT: begin
          for (int r = 0; r < MAX_REGIONS; r++)
            need_q[r] <= (r < nreg) && !deficit_q[r][16] && (deficit_q[r] != '0);
          picked_q <= '0; cnt_q <= '0; found_q <= 1'b0; out_k_q <= '0;
          clone_sum_q <= {1'b0, start_clone_q}; micro_sum_q <= {1'b0, start_micro_q};
        end
        ST_CHECK: begin
          idx_q <= '0; found_q <= 1'b0;
          fb_q <= 1'b0;
        end
        ST_SCAN: begin
          if (ncand != 6'd0 && !picked_q[ci] && fit && help != '0 && better) begin
            found_q <= 1'b1;
          end
          idx_q <= idx_q + 6'd1;
        end
        ST_APPLY: begin
          if (found_q) begin
            cnt_q <= cnt_q + 6'd1;
            picked_q[best_q] <= 1'b1;
            clone_sum_q <= 17'(clone_sum_q[15:0] + cclone_q[best_q[CW-1:0]]);
            micro_sum_q <= 33'(micro_sum_q[31:0] + cmicro_q[best_q[CW-1:0]]);
            for (int r = 0; r < NR; r++)
              if (cmask_q[best_q[CW-1:0]][r] && need_q[r] && r < nreg) begin
                if (work_q[r] == 17'd1) need_q[r] <= 1'b0;
              end
          end else begin
            fb_q <= |need_q;
          end
        end
        ST_EMIT: if (out_take) out_k_q <= out_k_q + 6'd1;
        default: ;
      endcase
    end
  end

  // payload-side working registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_INIT)
      for (int r = 0; r < MAX_REGIONS; r++) work_q[r] <= deficit_q[r];
    if (state_q == ST_SCAN && ncand != 6'd0 && !picked_q[ci] && fit && help != '0 && better)
    begin
      best_q <= ci; best_help_q <= help;
      best_ben_q <= cben_q[ci[CW-1:0]]; best_micro_q <= cmicro_q[ci[CW-1:0]];
    end
    if (state_q == ST_APPLY && found_q) begin
      order_q[cnt_q[4:0]] <= best_q;
      for (int r = 0; r < NR; r++)
        if (cmask_q[best_q[CW-1:0]][r] && need_q[r] && r < nreg) work_q[r] <= work_q[r] - 17'd1;
    end
  end

  // output
  logic has; logic [15:0] tot_c; logic [31:0] tot_m;
  assign has = !fb_q && cnt_q != '0;
  assign tot_c = fb_q ? 16'd0 : clone_sum_q[15:0];
  assign tot_m = fb_q ? 32'd0 : micro_sum_q[31:0];
  assign out_valid = state_q == ST_EMIT;
  assign m_axis_tvalid = out_valid;
  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tlast = !has || (out_k_q + 6'd1 == cnt_q);
  assign m_axis_tdata = {1'b0, tot_m, tot_c, fb_q, has, has ? order_q[out_k_q[4:0]] : 5'd0};

  `BGCS_ASSERT(a_no_in_while_busy, (state_q != ST_IDLE) |-> !s_axis_tready, "busy but ready")
  `BGCS_ASSERT_NEVER(a_fb_with_choice, m_axis_tvalid && m_axis_tdata[6] && m_axis_tdata[5], "fallback with choice")
  `BGCS_ASSERT_NEVER(a_cnt_bound, cnt_q > max_sel_q && state_q == ST_EMIT, "too many picks")
endmodule

// ----- tb/bgcs_checker.sv -----
// scoreboard for the greedy cover selector: mirrors config writes, predicts
// the result transactions of every run and compares them with the output.
// depends on bgcs_pkg.
`timescale 1ns / 100ps
module bgcs_checker import bgcs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [55:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           runs_o,
  output int           results_o,
  output int           fallbacks_o
);

  typedef struct packed {
    logic [4:0]  slot;
    logic        has;
    logic        fb;
    logic [15:0] tclone;
    logic [31:0] tmicro;
    logic        last;
  } pick_t;

  pick_t pick_q[$];

  // mirrored configuration
  logic [4:0]  region_cnt;
  logic [5:0]  cand_cnt;
  logic [5:0]  sel_max;
  logic [15:0] clone_max;
  logic [31:0] micro_max;
  logic [15:0] clone_start;
  logic [31:0] micro_start;

  // mirrored stores
  logic signed [16:0] deficit_q[16];
  logic [15:0] cmask[32];
  logic [15:0] cbenefit[32];
  logic [15:0] cclone[32];
  logic [31:0] cmicro[32];

  // appends one expected result transaction
  function automatic void queue_pick(pick_t p);
    pick_q.insert(pick_q.size(), p);
  endfunction

  // greedy selection for one run, queues its result transactions
  task automatic predict_run();
    int nreg, ncand, cnt, best, best_help, h, c, r;
    int work[16];
    int order[32];
    logic [31:0] picked;
    longint csum, msum;
    bit found, better, unmet;
    nreg  = (region_cnt > 16) ? 16 : region_cnt;
    ncand = (cand_cnt > 32) ? 32 : cand_cnt;
    for (r = 0; r < 16; r++) work[r] = (r < nreg) ? int'(deficit_q[r]) : 0;
    picked = '0;
    cnt = 0;
    csum = clone_start;
    msum = micro_start;
    forever begin
      unmet = 0;
      for (r = 0; r < nreg; r++) if (work[r] > 0) unmet = 1;
      if (!unmet) break;
      found = 0;
      best = 0;
      best_help = 0;
      for (c = 0; c < ncand; c++) begin
        if (picked[c]) continue;
        if (cnt >= sel_max) continue;
        if (csum > clone_max || longint'(cclone[c]) > clone_max - csum) continue;
        if (msum > micro_max || longint'(cmicro[c]) > micro_max - msum) continue;
        h = 0;
        for (r = 0; r < nreg; r++) if (cmask[c][r] && work[r] > 0) h++;
        if (h == 0) continue;
        if (!found) better = 1;
        else if (h != best_help) better = h > best_help;
        else if (cbenefit[c] != cbenefit[best]) better = cbenefit[c] > cbenefit[best];
        else better = cmicro[c] < cmicro[best];
        if (better) begin
          found = 1;
          best = c;
          best_help = h;
        end
      end
      if (!found) break;
      order[cnt] = best;
      cnt++;
      picked[best] = 1'b1;
      csum += cclone[best];
      msum += cmicro[best];
      for (r = 0; r < nreg; r++) if (cmask[best][r] && work[r] > 0) work[r]--;
    end
    unmet = 0;
    for (r = 0; r < nreg; r++) if (work[r] > 0) unmet = 1;
    if (unmet) begin
      queue_pick('{5'd0, 1'b0, 1'b1, 16'd0, 32'd0, 1'b1});
    end else if (cnt == 0) begin
      queue_pick('{5'd0, 1'b0, 1'b0, csum[15:0], msum[31:0], 1'b1});
    end else begin
      for (c = 0; c < cnt; c++)
        queue_pick('{order[c][4:0], 1'b1, 1'b0, csum[15:0], msum[31:0],
                     c == cnt - 1});
    end
  endtask

  assign pending_o = pick_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t want, got;
    func_e fn;
    logic [4:0] slot;
    if (!rst_ni) begin
      region_cnt   <= '0;
      cand_cnt     <= '0;
      sel_max      <= 6'd32;
      clone_max    <= 16'hffff;
      micro_max    <= 32'hffffffff;
      clone_start  <= '0;
      micro_start  <= '0;
      fail_count_o <= 0;
      runs_o       <= 0;
      results_o    <= 0;
      fallbacks_o  <= 0;
      pick_q.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_REGION_COUNT: region_cnt  <= cfg_data_i[4:0];
          CFG_CAND_COUNT:   cand_cnt    <= cfg_data_i[5:0];
          CFG_MAX_SELECTED: sel_max     <= cfg_data_i[5:0];
          CFG_MAX_CLONE:    clone_max   <= cfg_data_i[15:0];
          CFG_MAX_MICRO:    micro_max   <= cfg_data_i;
          CFG_START_CLONE:  clone_start <= cfg_data_i[15:0];
          CFG_START_MICRO:  micro_start <= cfg_data_i;
          default: ;
        endcase
      end
      // result transaction
      if (m_axis_tvalid && m_axis_tready) begin
        results_o <= results_o + 1;
        got = '{m_axis_tdata[4:0], m_axis_tdata[5], m_axis_tdata[6],
                m_axis_tdata[22:7], m_axis_tdata[54:23], m_axis_tlast};
        if (got.fb) fallbacks_o <= fallbacks_o + 1;
        if (pick_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %p", got);
        end else begin
          want = pick_q.pop_front();
          if (got !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      // input transaction
      if (s_axis_tvalid && s_axis_tready) begin
        fn = func_e'(s_axis_tdata[1:0]);
        slot = s_axis_tdata[6:2];
        case (fn)
          FUNC_LOAD_REGION: if (slot < 16)
            deficit_q[slot] = $signed({1'b0, s_axis_tdata[22:7]})
                              - $signed({1'b0, s_axis_tdata[38:23]});
          FUNC_LOAD_CAND: begin
            cmask[slot]    = s_axis_tdata[54:39];
            cbenefit[slot] = s_axis_tdata[70:55];
            cclone[slot]   = s_axis_tdata[86:71];
            cmicro[slot]   = s_axis_tdata[118:87];
          end
          FUNC_RUN: begin
            runs_o <= runs_o + 1;
            predict_run();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// top of the greedy cover selector testbench: clock, reset, stimulus phases
// with config changes and random idling, verdict. depends on bgcs_pkg and bgcs_checker.
`timescale 1ns / 100ps
module tb;
  import bgcs_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int HOLD_LEN = 600;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  int fail_count, pending, runs, results, fallbacks;
  int send_idle_pct, recv_stall_pct;
  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_cycles = 0;
  int cycles = 0;
  bit region_ok[16];
  bit cand_ok[32];
  int nreg_use, ncand_use;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  budgeted_greedy_cover_select u_dut (.*);

  bgcs_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .runs_o(runs),
    .results_o(results), .fallbacks_o(fallbacks)
  );

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_cycles <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // one input transaction, then maybe a gap
  task automatic send(func_e fn, logic [4:0] slot, logic [15:0] peak, logic [15:0] tgt,
                      logic [15:0] mask, logic [15:0] ben, logic [15:0] clone,
                      logic [31:0] micro);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, micro, clone, ben, mask, tgt, peak, slot, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    if (fn == FUNC_LOAD_REGION && slot < 16) region_ok[slot] = 1;
    if (fn == FUNC_LOAD_CAND) cand_ok[slot] = 1;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  // transaction of the given function with every other field random
  task automatic send_rand(func_e fn);
    send(fn, 5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom), $urandom);
  endtask

  task automatic wait_idle(int tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // writes all seven registers back to back
  task automatic configure(logic [4:0] rc, logic [5:0] cc, logic [5:0] msel,
                           logic [15:0] mclone, logic [31:0] mmicro,
                           logic [15:0] sclone, logic [31:0] smicro);
    logic [31:0] vals[7];
    vals = '{32'(rc), 32'(cc), 32'(msel), 32'(mclone), mmicro, 32'(sclone), smicro};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    nreg_use  = (rc > 16) ? 16 : rc;
    ncand_use = (cc > 32) ? 32 : cc;
  endtask

  // region load with a small deficit most of the time
  task automatic load_region(logic [4:0] slot);
    logic [15:0] tgt, peak;
    tgt = 16'($urandom);
    peak = 16'(32'(tgt) + $urandom_range(5) - 2);
    if ($urandom_range(9) < 2) peak = 16'($urandom);
    send(FUNC_LOAD_REGION, slot, peak, tgt, 16'($urandom), 16'($urandom), 16'($urandom),
         $urandom);
  endtask

  task automatic load_cand(logic [4:0] slot);
    logic [15:0] mask, ben, clone;
    logic [31:0] micro;
    mask = 16'($urandom & $urandom);
    ben = 16'($urandom_range(3));
    clone = 16'($urandom_range(20));
    micro = $urandom_range(6);
    if ($urandom_range(9) == 0) begin
      mask = 16'($urandom);
      ben = 16'($urandom);
      clone = 16'($urandom);
      micro = $urandom;
    end
    send(FUNC_LOAD_CAND, slot, 16'($urandom), 16'($urandom), mask, ben, clone, micro);
  endtask

  // fill any in-use entry not yet loaded, then random traffic
  task automatic phase_traffic(int n);
    int pick;
    for (int r = 0; r < nreg_use; r++) if (!region_ok[r]) load_region(5'(r));
    for (int c = 0; c < ncand_use; c++) if (!cand_ok[c]) load_cand(5'(c));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) load_region(5'($urandom_range(31)));
      else if (pick < 65) load_cand(5'($urandom_range(31)));
      else if (pick < 95) send_rand(FUNC_RUN);
      else send_rand(FUNC_NONE);
    end
    send(FUNC_RUN, '0, '0, '0, '0, '0, '0, '0);
    wait_idle(8);
  endtask

  initial begin
    send_idle_pct = 6;
    recv_stall_pct = 86;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty run, unused code, ignored and extreme loads
    configure(5'd0, 6'd0, 6'd32, 16'hffff, 32'hffffffff, 16'd0, 32'd0);
    send(FUNC_RUN, '0, '0, '0, '0, '0, '0, '0);
    send(FUNC_NONE, 5'd31, '1, '1, '1, '1, '1, '1);
    send(FUNC_LOAD_REGION, 5'd31, 16'hffff, 16'h0, '0, '0, '0, '0);
    send(FUNC_LOAD_REGION, 5'd0, 16'hffff, 16'h0, '0, '0, '0, '0);
    send(FUNC_LOAD_REGION, 5'd15, 16'h0, 16'hffff, '0, '0, '0, '0);
    send(FUNC_LOAD_CAND, 5'd31, '1, '1, '1, '1, '1, '1);
    send(FUNC_LOAD_CAND, 5'd0, '0, '0, '0, '0, '0, '0);
    send(FUNC_RUN, '0, '0, '0, '0, '0, '0, '0);
    wait_idle(8);
    region_ok[0] = 0;
    cand_ok[31] = 0;
    cand_ok[0] = 0;

    configure(5'd5, 6'd8, 6'd32, 16'hffff, 32'hffffffff, 16'd0, 32'd0);
    phase_traffic(10);
    // clamped counts, starts equal to budgets
    configure(5'd31, 6'd63, 6'd32, 16'hffff, 32'hffffffff, 16'hffff, 32'hffffffff);
    phase_traffic(8);

    send_idle_pct = 86;
    recv_stall_pct = 6;
    // no picks allowed
    configure(5'd6, 6'd10, 6'd0, 16'd100, 32'd1000, 16'd0, 32'd0);
    phase_traffic(8);
    // clone start above its budget; long receiver hold-off
    configure(5'd8, 6'd12, 6'd3, 16'd30, 32'd50, 16'd40, 32'd0);
    send_idle_pct = 0;
    hold_req_cnt = hold_req_cnt + 1;
    phase_traffic(10);
    send_idle_pct = 86;
    configure(5'($urandom_range(1, 16)), 6'($urandom_range(1, 32)),
              6'($urandom_range(1, 8)), 16'($urandom_range(10, 200)),
              $urandom_range(0, 20), 16'($urandom_range(5)), $urandom_range(3));
    phase_traffic(10);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    // zero budgets, full sizes
    configure(5'd16, 6'd32, 6'd32, 16'd0, 32'd0, 16'd0, 32'd0);
    phase_traffic(8);
    configure(5'd16, 6'd32, 6'd32, 16'hffff, 32'hffffffff, 16'd0, 32'd0);
    phase_traffic(8);
    wait_idle(50);

    $display("covered %0d runs and %0d result transactions (%0d fallbacks)",
             runs, results, fallbacks);
    $display("budgets swept from zero to full scale, counts up to the clamp");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
